FILE: hdl/cfgns_pkg.sv
`timescale 1ns / 1ps
// Package for the cube face grid neighbor step: face and edge codes, register
// map and the face-crossing remap table. Depends on nothing.
package cfgns_pkg;

  localparam int COORD_W = 12;
  localparam int RES_W   = 13;
  localparam int FACE_W  = 3;
  localparam int STEP_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [RES_W-1:0] MAX_RESOLUTION = RES_W'(4096);
  localparam logic [RES_W-1:0] RES_RESET      = RES_W'(64);

  // register index, taken from paddr[2]
  localparam logic REG_FACE_RESOLUTION = 1'b0;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  localparam logic [1:0] EDGE_NX = 2'd0;
  localparam logic [1:0] EDGE_PX = 2'd1;
  localparam logic [1:0] EDGE_NY = 2'd2;
  localparam logic [1:0] EDGE_PY = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic               hit;
    logic [FACE_W-1:0]  face;
    coord_t             x;
    coord_t             y;
  } remap_t;

  // Neighbor face and remapped cell for a step off the given edge.
  function automatic remap_t cross_edge(input logic [FACE_W-1:0] face,
                                        input logic [1:0] edge_code,
                                        input coord_t x, input coord_t y,
                                        input coord_t m);
    remap_t r;
    coord_t mx;
    coord_t my;
    mx = m - x;
    my = m - y;
    r.hit  = 1'b1;
    r.face = face;
    r.x    = x;
    r.y    = y;
    case (face)
      FACE_PX: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_NY; r.x = m;        r.y = y;        end
          EDGE_PX: begin r.face = FACE_PY; r.x = '0;       r.y = y;        end
          EDGE_NY: begin r.face = FACE_NZ; r.x = mx;       r.y = '0;       end
          default: begin r.face = FACE_PZ; r.x = mx;       r.y = m;        end
        endcase
      end
      FACE_NX: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_PY; r.x = m;        r.y = y;        end
          EDGE_PX: begin r.face = FACE_NY; r.x = '0;       r.y = y;        end
          EDGE_NY: begin r.face = FACE_NZ; r.x = x;        r.y = m;        end
          default: begin r.face = FACE_PZ; r.x = x;        r.y = '0;       end
        endcase
      end
      FACE_PY: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_PX; r.x = m;        r.y = y;        end
          EDGE_PX: begin r.face = FACE_NX; r.x = '0;       r.y = y;        end
          EDGE_NY: begin r.face = FACE_NZ; r.x = '0;       r.y = x;        end
          default: begin r.face = FACE_PZ; r.x = '0;       r.y = mx;       end
        endcase
      end
      FACE_NY: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_NX; r.x = m;        r.y = y;        end
          EDGE_PX: begin r.face = FACE_PX; r.x = '0;       r.y = y;        end
          EDGE_NY: begin r.face = FACE_NZ; r.x = m;        r.y = mx;       end
          default: begin r.face = FACE_PZ; r.x = m;        r.y = x;        end
        endcase
      end
      FACE_PZ: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_PY; r.x = my;       r.y = m;        end
          EDGE_PX: begin r.face = FACE_NY; r.x = y;        r.y = m;        end
          EDGE_NY: begin r.face = FACE_NX; r.x = x;        r.y = m;        end
          default: begin r.face = FACE_PX; r.x = mx;       r.y = m;        end
        endcase
      end
      FACE_NZ: begin
        case (edge_code)
          EDGE_NX: begin r.face = FACE_PY; r.x = y;        r.y = '0;       end
          EDGE_PX: begin r.face = FACE_NY; r.x = my;       r.y = '0;       end
          EDGE_NY: begin r.face = FACE_PX; r.x = mx;       r.y = '0;       end
          default: begin r.face = FACE_NX; r.x = x;        r.y = '0;       end
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cube_face_grid_neighbor_step.sv
`timescale 1ns / 1ps
// Cube face grid neighbor step: input register, remap logic, result register.
// Depends on cfgns_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one cell and a unit step per
//   beat: from_face, from_x, from_y, step_x, step_y. Output channel
//   (out_valid / out_stall) returns one beat per input beat with the new
//   display cell, its canonical coordinates and the crossed_edge flag.
//   A beat is moved at a rising edge where valid is high and stall is low.
//   A beat passes through the input register, then the result register.
//   Throughput: one beat per cycle while out_stall is low; the remap is one pass
//   of compares, subtracts and table selection between the input and result registers.
//   When the receiver stalls, the result register holds its beat and an empty input
//   register still takes one more beat before in_stall rises. face_resolution is
//   written over the APB-style port at byte address 0; the user must write it only
//   while the block is idle, as the block does not enforce this. Reads return it.
//   Reset (rst, synchronous) empties both registers and sets face_resolution to 64.
module cube_face_grid_neighbor_step (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cfgns_pkg::ADDR_W-1:0]       paddr,
  input  logic [cfgns_pkg::DATA_W-1:0]       pwdata,
  output logic [cfgns_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cfgns_pkg::FACE_W-1:0]       from_face,
  input  logic [cfgns_pkg::COORD_W-1:0]      from_x,
  input  logic [cfgns_pkg::COORD_W-1:0]      from_y,
  input  logic signed [cfgns_pkg::STEP_W-1:0] step_x,
  input  logic signed [cfgns_pkg::STEP_W-1:0] step_y,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cfgns_pkg::FACE_W-1:0]       next_face,
  output logic [cfgns_pkg::COORD_W-1:0]      next_x,
  output logic [cfgns_pkg::COORD_W-1:0]      next_y,
  output logic [cfgns_pkg::COORD_W-1:0]      canon_x,
  output logic [cfgns_pkg::COORD_W-1:0]      canon_y,
  output logic                               crossed_edge
);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [cfgns_pkg::RES_W-1:0] face_resolution;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == cfgns_pkg::REG_FACE_RESOLUTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      face_resolution <= cfgns_pkg::RES_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      face_resolution <= pwdata[cfgns_pkg::RES_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[cfgns_pkg::RES_W-1:0] = face_resolution;
    end
  end

  // Effective resolution: zero reads as one, saturate at the maximum.
  logic [cfgns_pkg::RES_W-1:0] res;
  cfgns_pkg::coord_t           res_m;

  always_comb begin
    if (face_resolution == '0) begin
      res = cfgns_pkg::RES_W'(1);
    end else if (face_resolution > cfgns_pkg::MAX_RESOLUTION) begin
      res = cfgns_pkg::MAX_RESOLUTION;
    end else begin
      res = face_resolution;
    end
  end

  // res is at least one, so res - 1 fits the coordinate width
  assign res_m = cfgns_pkg::COORD_W'(res - cfgns_pkg::RES_W'(1));

  // ---------------------------------------------------------------------
  // Handshake: each stage loads when empty or when its beat moves on
  // ---------------------------------------------------------------------
  logic in_valid_q;
  logic load_out;
  logic load_in;

  assign load_out = !out_valid || !out_stall;
  assign in_stall = in_valid_q && !load_out;
  assign load_in  = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic [cfgns_pkg::FACE_W-1:0] face_q;
  cfgns_pkg::coord_t            x_q;
  cfgns_pkg::coord_t            y_q;
  logic [cfgns_pkg::STEP_W-1:0] sx_q;
  logic [cfgns_pkg::STEP_W-1:0] sy_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= 1'b1;
    end else if (load_out) begin
      in_valid_q <= 1'b0;
    end
  end

  // hold payload unless a new beat is taken
  always_ff @(posedge clk) begin
    if (load_in) begin
      face_q <= from_face;
      x_q    <= from_x;
      y_q    <= from_y;
      sx_q   <= step_x;
      sy_q   <= step_y;
    end
  end

  // ---------------------------------------------------------------------
  // Step and remap
  // ---------------------------------------------------------------------
  logic                         use_x;
  logic                         moving;
  logic                         neg;
  cfgns_pkg::coord_t            v;
  logic [cfgns_pkg::RES_W-1:0]  v_wide;
  logic [cfgns_pkg::RES_W-1:0]  t_wide;
  logic                         in_range;
  logic [1:0]                   edge_code;
  cfgns_pkg::remap_t            remap;

  logic [cfgns_pkg::FACE_W-1:0] face_next;
  cfgns_pkg::coord_t            x_next;
  cfgns_pkg::coord_t            y_next;
  cfgns_pkg::coord_t            cx_next;
  cfgns_pkg::coord_t            cy_next;
  logic                         crossed_next;

  always_comb begin
    // a nonzero x step wins over the y step; only the sign bit counts
    use_x  = (sx_q != '0);
    moving = use_x || (sy_q != '0);
    neg    = use_x ? sx_q[cfgns_pkg::STEP_W-1] : sy_q[cfgns_pkg::STEP_W-1];
    v      = use_x ? x_q : y_q;
    v_wide = {1'b0, v};

    if (neg) begin
      t_wide   = v_wide - cfgns_pkg::RES_W'(1);
      in_range = (v != '0) && (t_wide < res);
    end else begin
      t_wide   = v_wide + cfgns_pkg::RES_W'(1);
      in_range = (t_wide < res);
    end

    edge_code = {!use_x, !neg};
    remap     = cfgns_pkg::cross_edge(face_q, edge_code, x_q, y_q, res_m);

    face_next    = face_q;
    x_next       = x_q;
    y_next       = y_q;
    crossed_next = 1'b0;

    if (moving) begin
      if (in_range) begin
        if (use_x) begin
          x_next = t_wide[cfgns_pkg::COORD_W-1:0];
        end else begin
          y_next = t_wide[cfgns_pkg::COORD_W-1:0];
        end
      end else if (remap.hit) begin
        // stepping off an unused face code leaves the cell in place
        face_next    = remap.face;
        x_next       = remap.x;
        y_next       = remap.y;
        crossed_next = 1'b1;
      end
    end

    // mirror canonical coordinates on the z faces
    if (face_next == cfgns_pkg::FACE_PZ || face_next == cfgns_pkg::FACE_NZ) begin
      cx_next = res_m - x_next;
      cy_next = res_m - y_next;
    end else begin
      cx_next = x_next;
      cy_next = y_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && in_valid_q) begin
      next_face    <= face_next;
      next_x       <= x_next;
      next_y       <= y_next;
      canon_x      <= cx_next;
      canon_y      <= cy_next;
      crossed_edge <= crossed_next;
    end
  end

endmodule
